/* rtl/core/lzw_pkg.sv */
// Shared constants, dictionary entry layout and controller/datapath bundles
// for the LZW encoder. No dependencies.
`timescale 1ns / 1ps

package lzw_pkg;

  localparam int CODE_COUNT = 1024;
  localparam int HASH_SLOTS = 1024;                 // power of two
  localparam int CODE_W     = $clog2(CODE_COUNT);
  localparam int HASH_BITS  = $clog2(HASH_SLOTS);
  localparam int BYTE_W     = 8;
  localparam int FIRST_FREE = 256;
  localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] prefix;
    logic [BYTE_W-1:0] data;
    logic [CODE_W-1:0] code;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic accept;       // latch input item, seed prefix if empty
    logic hash_load;    // register hashed slot address
    logic probe_next;   // step to next slot on collision
    logic take_hit;     // matched entry becomes the prefix
    logic commit_miss;  // emit prefix, insert pair if codes remain, restart from byte
    logic emit_final;   // emit final code and reset stream state
    logic clear_step;   // zero one dictionary slot
  } cmd_t;

  typedef struct packed {
    logic prefix_empty;
    logic eos;
    logic hit;
    logic free_slot;
    logic out_free;
    logic clear_done;
  } status_t;

endpackage

/* rtl/core/lzw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lzw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wen,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/lzw_ctrl.sv */
// Controller state machine of the LZW encoder: clear sweep, accept, hash,
// probe and emit sequencing. Depends on lzw_pkg.
`timescale 1ns / 1ps

module lzw_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_last,
  output logic             in_ready,
  input  lzw_pkg::status_t st,
  output lzw_pkg::cmd_t    cmd
);
  import lzw_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR   = 6'b000001,
    S_IDLE    = 6'b000010,
    S_HASH    = 6'b000100,
    S_READ    = 6'b001000,
    S_COMPARE = 6'b010000,
    S_FINAL   = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (st.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (!st.prefix_empty) begin
            state_next = S_HASH;
          end else if (in_last) begin
            state_next = S_FINAL;
          end
        end
      end
      S_HASH: begin
        cmd.hash_load = 1'b1;
        state_next    = S_READ;
      end
      S_READ: begin
        state_next = S_COMPARE;
      end
      S_COMPARE: begin
        if (st.hit) begin
          cmd.take_hit = 1'b1;
          state_next   = st.eos ? S_FINAL : S_IDLE;
        end else if (st.free_slot) begin
          // hold until the output register can take the prefix code
          if (st.out_free) begin
            cmd.commit_miss = 1'b1;
            state_next      = st.eos ? S_FINAL : S_IDLE;
          end
        end else begin
          cmd.probe_next = 1'b1;
          state_next     = S_READ;
        end
      end
      S_FINAL: begin
        if (st.out_free) begin
          cmd.emit_final = 1'b1;
          state_next     = S_CLEAR;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

/* rtl/core/lzw_dp.sv */
// Datapath of the LZW encoder: prefix state, hash and probe address,
// dictionary RAM and output register. Depends on lzw_pkg and lzw_ram.
`timescale 1ns / 1ps

module lzw_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [lzw_pkg::BYTE_W-1:0] in_byte,
  input  logic                      in_last,
  input  lzw_pkg::cmd_t             cmd,
  output lzw_pkg::status_t          st,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [lzw_pkg::CODE_W-1:0] out_code,
  output logic                      out_last
);
  import lzw_pkg::*;

  logic [BYTE_W-1:0]    byte_q;
  logic                 eos_q;
  logic [CODE_W-1:0]    prefix_code;
  logic                 prefix_empty;
  logic [CODE_W:0]      next_free_code;
  logic [HASH_BITS-1:0] probe_addr;
  logic [HASH_BITS-1:0] clear_addr;

  logic [CODE_W+BYTE_W-1:0] hash_key;
  logic [31:0]              hash_prod;
  logic                     room;
  logic                     out_free;
  entry_t                   rd_entry;
  entry_t                   wr_entry;
  logic [ENTRY_W-1:0]       rd_raw;
  logic                     ram_wen;
  logic [HASH_BITS-1:0]     ram_waddr;

  assign hash_key  = {prefix_code, byte_q};
  assign hash_prod = 32'(hash_key) * HASH_MULT;
  assign room      = next_free_code < (CODE_W+1)'(CODE_COUNT);
  assign out_free  = !out_valid || out_ready;
  assign rd_entry  = entry_t'(rd_raw);

  always_comb begin
    wr_entry = '0;
    if (!cmd.clear_step) begin
      wr_entry.valid  = 1'b1;
      wr_entry.prefix = prefix_code;
      wr_entry.data   = byte_q;
      wr_entry.code   = next_free_code[CODE_W-1:0];
    end
  end

  assign ram_wen   = cmd.clear_step || (cmd.commit_miss && room);
  assign ram_waddr = cmd.clear_step ? clear_addr : probe_addr;

  lzw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (HASH_SLOTS)
  ) u_dict (
    .clk   (clk),
    .wen   (ram_wen),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .raddr (probe_addr),
    .rdata (rd_raw)
  );

  always_comb begin
    st.prefix_empty = prefix_empty;
    st.eos          = eos_q;
    st.hit          = rd_entry.valid && (rd_entry.prefix == prefix_code)
                      && (rd_entry.data == byte_q);
    st.free_slot    = !rd_entry.valid;
    st.out_free     = out_free;
    st.clear_done   = &clear_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_code    <= '0;
      prefix_empty   <= 1'b1;
      next_free_code <= (CODE_W+1)'(FIRST_FREE);
      clear_addr     <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.commit_miss || cmd.emit_final) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.clear_step) begin
        clear_addr <= clear_addr + 1'b1;  // wraps back to zero at the end
      end
      if (cmd.accept && prefix_empty) begin
        prefix_code  <= CODE_W'(in_byte);
        prefix_empty <= 1'b0;
      end
      if (cmd.take_hit) begin
        prefix_code <= rd_entry.code;
      end
      if (cmd.commit_miss) begin
        prefix_code <= CODE_W'(byte_q);
        if (room) begin
          next_free_code <= next_free_code + 1'b1;
        end
      end
      if (cmd.emit_final) begin
        prefix_code    <= '0;
        prefix_empty   <= 1'b1;
        next_free_code <= (CODE_W+1)'(FIRST_FREE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_q <= in_byte;
      eos_q  <= in_last;
    end
    if (cmd.hash_load) begin
      probe_addr <= hash_prod[HASH_BITS-1:0];
    end else if (cmd.probe_next) begin
      probe_addr <= probe_addr + 1'b1;
    end
    if (cmd.commit_miss || cmd.emit_final) begin
      out_code <= prefix_code;
      out_last <= cmd.emit_final;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit_miss || cmd.emit_final) |-> (!out_valid || out_ready))
    else $error("output register loaded while holding an unaccepted item");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit_miss || cmd.emit_final) |=> out_valid)
    else $error("emitted code not presented");

  a_free_range: assert property (@(posedge clk) disable iff (rst)
    (next_free_code >= (CODE_W+1)'(FIRST_FREE))
    && (next_free_code <= (CODE_W+1)'(CODE_COUNT)))
    else $error("next free code out of range");

  a_prefix_known: assert property (@(posedge clk) disable iff (rst)
    !prefix_empty |-> ((CODE_W+1)'(prefix_code) < next_free_code))
    else $error("prefix code not yet assigned");

endmodule

/* rtl/core/lzw_encoder.sv */
// Top level of the LZW encoder: stream ports, controller and datapath.
// Depends on lzw_pkg, lzw_ctrl and lzw_dp.
//
//   channel  | direction | payload
//   s_axis   | in        | tdata[7:0] in_byte, tlast end_of_stream
//   m_axis   | out       | tdata[9:0] code, tlast last_code
//
// An item that starts a stream is only accepted and seeds the prefix. Any
// other item takes accept, hash, dictionary read and compare steps, plus a
// read and compare per extra probe on a hash collision; the single read
// port of the dictionary RAM sets this. An end-of-stream item adds a final
// step to emit the final code. A code waiting in the output register stalls
// the compare or final step only when a new code must be emitted. After
// reset and after every end of stream a sweep clears all 1024 dictionary
// slots, during which no item is accepted. rst is synchronous and active high.
`timescale 1ns / 1ps

module lzw_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // end_of_stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [9:0] code, [15:10] zero
  output logic        m_axis_tlast    // last_code
);
  import lzw_pkg::*;

  cmd_t              cmd;
  status_t           st;
  logic [CODE_W-1:0] code;

  lzw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  lzw_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_byte   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .cmd       (cmd),
    .st        (st),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_code  (code),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = 16'(code);

endmodule
